>>> design/srpm_pkg.sv
package srpm_pkg;

  // Default digit limit for the rpm field
  localparam int MAX_DIGITS_DEF = 4;

  // Field widths
  localparam int RPM_W   = 14;
  localparam int MOTOR_W = 2;
  localparam int KIND_W  = 2;

  // Saturation limit of the running value
  localparam logic [RPM_W-1:0] ACC_MAX = {RPM_W{1'b1}};

  // Event codes
  typedef enum logic [KIND_W-1:0] {
    EVT_MOTOR     = 2'd0,
    EVT_RPM       = 2'd1,
    EVT_ERR_LINE  = 2'd2,
    EVT_GOOD_LINE = 2'd3
  } evt_kind_t;

  // One event from the parser toward the result register
  typedef struct packed {
    logic               valid;
    evt_kind_t          kind;
    logic [MOTOR_W-1:0] motor;
    logic [RPM_W-1:0]   rpm;
  } evt_t;

endpackage

>>> design/srpm_fsm.sv
module srpm_fsm #(
  parameter int MAX_DIGITS = srpm_pkg::MAX_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        rx_byte,
  output srpm_pkg::evt_t    evt
);

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int PROD_W = srpm_pkg::RPM_W + 4;

  // Characters of the command form
  localparam logic [7:0] CH_S_LO = 8'h73;
  localparam logic [7:0] CH_R_LO = 8'h72;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_D_LO = 8'h64;
  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [3:0] {
    ST_START = 4'd0,
    ST_ERR   = 4'd1,
    ST_SET   = 4'd2,
    ST_RPM   = 4'd3,
    ST_MA    = 4'd4,
    ST_MB    = 4'd5,
    ST_MC    = 4'd6,
    ST_MD    = 4'd7,
    ST_END   = 4'd8
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [srpm_pkg::RPM_W-1:0]   acc_r, acc_nxt;

  logic [7:0]                   lower;
  logic                         is_digit;
  logic                         is_motor;
  logic [1:0]                   motor_sel;
  logic [PROD_W-1:0]            acc_ext;
  logic [PROD_W-1:0]            acc_sum;
  logic [srpm_pkg::RPM_W-1:0]   acc_sat;

  assign lower    = rx_byte | CASE_BIT;
  assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
  assign is_motor = (lower >= CH_A_LO) && (lower <= CH_D_LO);

  // Motor letter to index, wrapping in two bits so that d maps to 3
  assign motor_sel = lower[1:0] - CH_A_LO[1:0];

  // Multiply by ten as two shifts, add the digit, saturate
  assign acc_ext = PROD_W'(acc_r);
  assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(rx_byte - CH_0);
  assign acc_sat = (acc_sum > PROD_W'(srpm_pkg::ACC_MAX)) ? srpm_pkg::ACC_MAX
                                                          : acc_sum[srpm_pkg::RPM_W-1:0];

  // Next state and event for the current byte
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    evt       = '0;
    case (state_r)
      ST_ERR: begin
        if (rx_byte == CH_NL) begin
          state_nxt = ST_START;
          evt.valid = 1'b1;
          evt.kind  = srpm_pkg::EVT_ERR_LINE;
        end
      end
      ST_SET: begin
        state_nxt = (lower == CH_R_LO) ? ST_RPM : ST_ERR;
      end
      ST_RPM: begin
        if (is_motor) begin
          // Motor states sit at codes 4 to 7, the motor in the low two bits
          state_nxt = state_t'(ST_MA | {2'b00, motor_sel});
          evt.valid = 1'b1;
          evt.kind  = srpm_pkg::EVT_MOTOR;
          evt.motor = motor_sel;
        end else begin
          state_nxt = ST_ERR;
        end
      end
      ST_MA, ST_MB, ST_MC, ST_MD: begin
        if (is_digit) begin
          if (cnt_r < CNT_W'(MAX_DIGITS)) begin
            acc_nxt = acc_sat;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            state_nxt = ST_ERR;
          end
        end else if ((rx_byte == CH_SP) && (cnt_r != '0)) begin
          state_nxt = ST_END;
          evt.valid = 1'b1;
          evt.kind  = srpm_pkg::EVT_RPM;
          evt.motor = state_r[1:0];
          evt.rpm   = acc_r;
        end else begin
          state_nxt = ST_ERR;
        end
      end
      ST_END: begin
        if (rx_byte == CH_NL) begin
          state_nxt = ST_START;
          evt.valid = 1'b1;
          evt.kind  = srpm_pkg::EVT_GOOD_LINE;
        end
      end
      default: begin
        // Line start: clear the value and look for s
        cnt_nxt = '0;
        acc_nxt = '0;
        if (lower == CH_S_LO) begin
          state_nxt = ST_SET;
        end else if (rx_byte != CH_NL) begin
          state_nxt = ST_ERR;
        end else begin
          state_nxt = ST_START;
        end
      end
    endcase
  end

  // Advance the parse state once per byte taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      cnt_r   <= '0;
      acc_r   <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

>>> design/serial_rpm_command_parser_core.sv
// Channel  | Direction | Handshake        | Payload
// in_      | input     | in_valid/stall   | in_rx_byte
// out_     | output    | out_valid/stall  | out_event_kind, out_motor_index, out_rpm_value
//
// An event shows on out_ after its byte is accepted: the byte sits in the
// input register, then the parser loads the result register. One byte is taken
// every cycle while in_stall is low; the parser state register closes the only loop.
// Reset (rst_n low, synchronous) returns the parser to line start and empties both registers.
// A stalled result holds; the input register keeps taking a byte while the result
// register is free or being taken, so in_stall rises only while out_stall holds a result.
module serial_rpm_command_parser_core #(
  parameter int MAX_DIGITS = srpm_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [srpm_pkg::KIND_W-1:0]         out_event_kind,
  output logic [srpm_pkg::MOTOR_W-1:0]        out_motor_index,
  output logic [srpm_pkg::RPM_W-1:0]          out_rpm_value
);

  logic                               s1_valid_r;
  logic [7:0]                         s1_byte_r;
  logic                               out_valid_r;
  logic [srpm_pkg::KIND_W-1:0]        out_kind_r;
  logic [srpm_pkg::MOTOR_W-1:0]       out_motor_r;
  logic [srpm_pkg::RPM_W-1:0]         out_rpm_r;

  logic                               out_free;
  logic                               step_en;
  logic                               in_take;
  srpm_pkg::evt_t                     evt;

  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  srpm_fsm #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .rx_byte (s1_byte_r),
    .evt     (evt)
  );

  // Input register: take a new item or drain the held one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (step_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Result register: load an event, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_en && evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && evt.valid) begin
      out_kind_r  <= evt.kind;
      out_motor_r <= evt.motor;
      out_rpm_r   <= evt.rpm;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_motor_index = out_motor_r;
  assign out_rpm_value   = out_rpm_r;

endmodule

>>> design/srpm_checker.sv
module srpm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [srpm_pkg::KIND_W-1:0]    out_event_kind,
  input logic [srpm_pkg::MOTOR_W-1:0]   out_motor_index,
  input logic [srpm_pkg::RPM_W-1:0]     out_rpm_value
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_event_kind) && $stable(out_motor_index)
       && $stable(out_rpm_value)))
    else $error("stalled result changed");

  // Only an rpm event carries a value
  a_rpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_kind != srpm_pkg::EVT_RPM)) |-> (out_rpm_value == '0))
    else $error("rpm value on a non-rpm event");

  // Line-end events carry no motor
  a_motor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_event_kind == srpm_pkg::EVT_ERR_LINE)
                   || (out_event_kind == srpm_pkg::EVT_GOOD_LINE)))
      |-> (out_motor_index == '0))
    else $error("motor index on a line-end event");

endmodule

bind serial_rpm_command_parser_core srpm_checker u_srpm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_event_kind  (out_event_kind),
  .out_motor_index (out_motor_index),
  .out_rpm_value   (out_rpm_value)
);
